// ----- rtl/lc_pll_vco_calibration_sequencer_defines.svh -----
// Assertion macros shared by the calibration sequencer files.
// Each macro samples on clk and is held off while arst_n is low.
`ifndef LC_PLL_VCO_CALIBRATION_SEQUENCER_DEFINES_SVH
`define LC_PLL_VCO_CALIBRATION_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define LCVC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lcvc assertion failed");

// next-cycle implication
`define LCVC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lcvc assertion failed");

`else

`define LCVC_ASSERT_IMPL(lbl, ante, cons)
`define LCVC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/lcvc_pkg.sv -----
package lcvc_pkg;

	// request kinds
	localparam logic [2:0] KIND_START   = 3'd0;
	localparam logic [2:0] KIND_AMP     = 3'd1;
	localparam logic [2:0] KIND_COUNT   = 3'd2;
	localparam logic [2:0] KIND_TIMEOUT = 3'd3;
	localparam logic [2:0] KIND_TRACK   = 3'd4;

	// sample wanted next
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_AMP   = 2'd1;
	localparam logic [1:0] REQ_COUNT = 2'd2;

	// comparator threshold
	localparam logic [1:0] TH_AMP    = 2'd0;
	localparam logic [1:0] TH_FREQ   = 2'd1;
	localparam logic [1:0] TH_IDLE   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TARGET = 2'd0;
	localparam logic [1:0] CFG_BAND   = 2'd1;
	localparam logic [1:0] CFG_RATE   = 2'd2;

	// temperature levels
	localparam logic [1:0] TEMP_COLD = 2'd1;
	localparam logic [1:0] TEMP_HOT  = 2'd2;

	localparam logic [3:0] HOLD_TOP    = 4'd10;
	localparam logic [3:0] HOLD_BOTTOM = 4'd0;
	localparam logic [3:0] HIST_LOCKED = 4'b0101;
	localparam logic [1:0] FAIL_LAST   = 2'd2;     // count before the third failure

	// DAC is {coarse[2:0], fine[4:0]}; carry between parts is a plain +/-1
	localparam logic [7:0] DAC_RELOAD     = {3'h3, 5'h10};
	localparam logic [4:0] DAC_FINE_START = 5'd15;
	localparam logic [2:0] DAC_CRS_BAND1  = 3'd5;
	localparam logic [2:0] DAC_CRS_BAND0  = 3'd4;
	localparam logic [4:0] CAP_FINE_TOP   = 5'h1f;
	localparam logic [2:0] CAP_IDX_LIMIT  = 3'd4;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_AMP_INIT = 3'd1,
		PH_MSB_CNT  = 3'd2,
		PH_MSB_CHK  = 3'd3,
		PH_AMP_MSB  = 3'd4,
		PH_LSB_CHK  = 3'd5,
		PH_LSB_CNT  = 3'd6,
		PH_AMP_LSB  = 3'd7
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] dac;
		logic [4:0] cap_fine;
		logic [2:0] cap_idx;
		logic [3:0] hist;
		logic [1:0] lo_fail;
		logic [1:0] hi_fail;
		logic       pass;
		logic       timed_out;
		logic       done;
	} state_t;

	typedef struct packed {
		logic        wr;
		logic        dac_only;   // tracking rewrites only the DAC bits
		logic [15:0] data;
	} save_t;

	typedef struct packed {
		logic [1:0] request;
		logic [4:0] dac_fine;
		logic [2:0] dac_coarse;
		logic [4:0] cap_fine;
		logic [3:0] cap_coarse_thermo;
		logic [2:0] cap_coarse_step;
		logic [1:0] threshold_select;
		logic       done_res;
		logic       pass;
	} result_t;

	function automatic logic [3:0] thermo(input logic [2:0] idx);
		logic [3:0] t;
		case (idx)
			3'd0:    t = 4'h0;
			3'd1:    t = 4'h1;
			3'd2:    t = 4'h3;
			3'd3:    t = 4'h7;
			default: t = 4'hf;
		endcase
		return t;
	endfunction

	function automatic state_t lsb_enter(input state_t s);
		state_t r;
		r = s;
		if (s.cap_fine != '0)
			r.cap_fine = s.cap_fine - 5'd1;
		r.phase = PH_LSB_CHK;
		return r;
	endfunction

	function automatic state_t amp_enter(input state_t s, input phase_t ph);
		state_t r;
		r = s;
		r.hist    = '0;
		r.lo_fail = '0;
		r.hi_fail = '0;
		r.phase   = ph;
		return r;
	endfunction

endpackage

// ----- rtl/lcvc_step.sv -----
module lcvc_step (
	input  lcvc_pkg::state_t  cur,
	input  logic [2:0]        kind,
	input  logic              amp_high,
	input  logic [15:0]       measured_count,
	input  logic [1:0]        temp_level,
	input  logic [3:0]        hold_index,
	input  logic [15:0]       target_count,
	input  logic              band_select,
	output lcvc_pkg::state_t  nxt,
	output lcvc_pkg::save_t   save,
	output lcvc_pkg::result_t res
);
	import lcvc_pkg::*;

	always_comb begin
		state_t     n;
		logic [3:0] hist_n;
		logic       amp_end;
		logic [2:0] idx_inc;

		n       = cur;
		hist_n  = {cur.hist[2:0], amp_high};
		amp_end = 1'b0;
		idx_inc = cur.cap_idx + 3'd1;
		save    = '0;

		unique case (kind)
			KIND_START: begin
				n.dac       = {band_select ? DAC_CRS_BAND1 : DAC_CRS_BAND0, DAC_FINE_START};
				n.cap_fine  = CAP_FINE_TOP;
				n.cap_idx   = '0;
				n.pass      = 1'b1;
				n.timed_out = 1'b0;
				n.done      = 1'b0;
				n           = amp_enter(n, PH_AMP_INIT);
			end
			KIND_AMP: begin
				if (cur.phase == PH_AMP_INIT || cur.phase == PH_AMP_MSB ||
				    cur.phase == PH_AMP_LSB) begin
					n.hist = hist_n;
					if (hist_n == HIST_LOCKED) begin
						amp_end = 1'b1;
					end else begin
						if (amp_high) begin
							if (cur.dac == '0) begin
								n.dac     = DAC_RELOAD;
								n.lo_fail = cur.lo_fail + 2'd1;
								if (cur.lo_fail == FAIL_LAST) begin
									n.pass  = 1'b0;
									amp_end = 1'b1;
								end
							end else begin
								n.dac = cur.dac - 8'd1;
							end
						end else begin
							if (cur.dac == '1) begin
								n.hi_fail = cur.hi_fail + 2'd1;
								if (cur.hi_fail == FAIL_LAST) begin
									n.pass  = 1'b0;
									amp_end = 1'b1;
								end
							end else begin
								n.dac = cur.dac + 8'd1;
							end
						end
						if (cur.timed_out)
							amp_end = 1'b1;
					end
					if (amp_end) begin
						if (cur.phase == PH_AMP_INIT)
							n.phase = PH_MSB_CNT;
						else if (cur.phase == PH_AMP_LSB)
							n.phase = PH_LSB_CNT;
						else if (cur.timed_out)
							n = lsb_enter(n);
						else
							n.phase = PH_MSB_CNT;
					end
				end else if (cur.phase == PH_MSB_CHK) begin
					if (!amp_high)
						n = amp_enter(n, PH_AMP_MSB);
					else if (cur.timed_out)
						n = lsb_enter(n);
					else
						n.phase = PH_MSB_CNT;
				end else if (cur.phase == PH_LSB_CHK) begin
					if (!amp_high)
						n = amp_enter(n, PH_AMP_LSB);
					else
						n.phase = PH_LSB_CNT;
				end
			end
			KIND_COUNT: begin
				if (cur.phase == PH_MSB_CNT) begin
					if (measured_count == target_count) begin
						save.wr = 1'b1;
						n.done  = 1'b1;
						n.phase = PH_IDLE;
					end else if (measured_count < target_count) begin
						n = lsb_enter(n);
					end else if (idx_inc >= CAP_IDX_LIMIT) begin
						n.cap_idx = CAP_IDX_LIMIT;
						n.pass    = 1'b0;
						n         = lsb_enter(n);
					end else begin
						n.cap_idx = idx_inc;
						n.phase   = PH_MSB_CHK;
					end
				end else if (cur.phase == PH_LSB_CNT) begin
					if (cur.cap_fine == '0) begin
						n.pass  = 1'b0;
						save.wr = 1'b1;
						n.done  = 1'b1;
						n.phase = PH_IDLE;
					end else if (measured_count < target_count && !cur.timed_out) begin
						n = lsb_enter(n);
					end else begin
						save.wr = 1'b1;
						n.done  = 1'b1;
						n.phase = PH_IDLE;
					end
				end
			end
			KIND_TIMEOUT: begin
				n.timed_out = 1'b1;
			end
			KIND_TRACK: begin
				if (cur.phase == PH_IDLE) begin
					if (temp_level == TEMP_HOT && hold_index == HOLD_TOP && amp_high) begin
						if (cur.dac != '0)
							n.dac = cur.dac - 8'd1;
					end else if ((temp_level == TEMP_COLD && hold_index == HOLD_BOTTOM) ||
					             !amp_high) begin
						if (cur.dac != '1)
							n.dac = cur.dac + 8'd1;
					end
					save.wr       = 1'b1;
					save.dac_only = 1'b1;
				end
			end
			default: begin
				n = cur;
			end
		endcase

		save.data = {n.cap_idx, n.cap_fine, n.dac};
		nxt       = n;

		res.dac_fine          = n.dac[4:0];
		res.dac_coarse        = n.dac[7:5];
		res.cap_fine          = n.cap_fine;
		res.cap_coarse_thermo = thermo(n.cap_idx);
		res.cap_coarse_step   = n.cap_idx;
		res.done_res          = n.done;
		res.pass              = n.pass;
		if (n.phase == PH_IDLE)
			res.request = REQ_NONE;
		else if (n.phase == PH_MSB_CNT || n.phase == PH_LSB_CNT)
			res.request = REQ_COUNT;
		else
			res.request = REQ_AMP;
		if (n.phase == PH_IDLE)
			res.threshold_select = TH_IDLE;
		else if (n.phase == PH_AMP_INIT)
			res.threshold_select = TH_AMP;
		else
			res.threshold_select = TH_FREQ;
	end

endmodule

// ----- rtl/lcvc_obuf.sv -----
`include "lc_pll_vco_calibration_sequencer_defines.svh"

module lcvc_obuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcvc_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output lcvc_pkg::result_t out_data
);
	import lcvc_pkg::*;

	result_t main_q;
	result_t skid_q;
	logic    main_vq;
	logic    skid_vq;
	logic    pop;

	assign pop       = main_vq && !out_stall;
	assign full      = skid_vq;
	assign out_valid = main_vq;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vq <= 1'b0;
			skid_vq <= 1'b0;
		end else if (skid_vq) begin
			if (pop) begin
				main_vq <= 1'b1;
				skid_vq <= 1'b0;
			end
		end else if (push) begin
			if (!main_vq || pop)
				main_vq <= 1'b1;
			else
				skid_vq <= 1'b1;
		end else if (pop) begin
			main_vq <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vq) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (!main_vq || pop)
				main_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

	`LCVC_ASSERT_IMPL(a_skid_behind_main, skid_vq, main_vq)
	`LCVC_ASSERT_NEXT(a_push_to_skid, push && main_vq && !pop, skid_vq)
	`LCVC_ASSERT_NEXT(a_skid_drains, skid_vq && pop, main_vq && !skid_vq)

endmodule

// ----- rtl/lc_pll_vco_calibration_sequencer.sv -----
// LC VCO calibration sequencer. Each accepted request (start, amplitude
// sample, frequency count, timeout or continuous track) updates the
// calibration state in the cycle it is taken and yields exactly one
// result: the DAC and capacitor codes, the sample wanted next, the
// comparator threshold, done and pass. A request can be taken every
// clock while in_stall is low; the result is registered in the output buffer.
// A two-deep output buffer lets the input keep flowing while a result
// waits, and in_stall rises only once both entries are held.
// The user must write configuration (target count, band, rate slot) through the cfg port
// only while no request is in flight; not enforced by the block: cfg_ready is always high.
`include "lc_pll_vco_calibration_sequencer_defines.svh"

module lc_pll_vco_calibration_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic        amp_high,
	input  logic [15:0] measured_count,
	input  logic [1:0]  temp_level,
	input  logic [3:0]  hold_index,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  request,
	output logic [4:0]  dac_fine,
	output logic [2:0]  dac_coarse,
	output logic [4:0]  cap_fine,
	output logic [3:0]  cap_coarse_thermo,
	output logic [2:0]  cap_coarse_step,
	output logic [1:0]  threshold_select,
	output logic        done_res,
	output logic        pass,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lcvc_pkg::*;

	// config registers
	logic [15:0] target_q;
	logic        band_q;
	logic        rate_q;

	// calibration state, updated on every accepted request
	state_t      state_q;
	state_t      state_nxt;
	save_t       save;
	result_t     res;
	result_t     res_out;
	logic        push;
	logic        full;

	// per-rate save slots: [7:0] DAC, [12:8] cap fine, [15:13] coarse index
	logic [15:0] saved_q [2];

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign push      = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			band_q   <= 1'b0;
			rate_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TARGET: target_q <= cfg_data;
				CFG_BAND:   band_q   <= cfg_data[0];
				CFG_RATE:   rate_q   <= cfg_data[0];
				default:    target_q <= target_q;   // unused index, dropped
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_IDLE;
			state_q.dac       <= '0;
			state_q.cap_fine  <= CAP_FINE_TOP;
			state_q.cap_idx   <= '0;
			state_q.hist      <= '0;
			state_q.lo_fail   <= '0;
			state_q.hi_fail   <= '0;
			state_q.pass      <= 1'b1;
			state_q.timed_out <= 1'b0;
			state_q.done      <= 1'b0;
		end else if (push) begin
			state_q <= state_nxt;
		end
	end

	// finish writes the whole slot, tracking rewrites only the DAC byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saved_q[0] <= '0;
			saved_q[1] <= '0;
		end else if (push && save.wr) begin
			if (save.dac_only)
				saved_q[rate_q][7:0] <= save.data[7:0];
			else
				saved_q[rate_q] <= save.data;
		end
	end

	lcvc_step u_step (
		.cur            (state_q),
		.kind           (kind),
		.amp_high       (amp_high),
		.measured_count (measured_count),
		.temp_level     (temp_level),
		.hold_index     (hold_index),
		.target_count   (target_q),
		.band_select    (band_q),
		.nxt            (state_nxt),
		.save           (save),
		.res            (res)
	);

	lcvc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	assign request           = res_out.request;
	assign dac_fine          = res_out.dac_fine;
	assign dac_coarse        = res_out.dac_coarse;
	assign cap_fine          = res_out.cap_fine;
	assign cap_coarse_thermo = res_out.cap_coarse_thermo;
	assign cap_coarse_step   = res_out.cap_coarse_step;
	assign threshold_select  = res_out.threshold_select;
	assign done_res          = res_out.done_res;
	assign pass              = res_out.pass;

	`LCVC_ASSERT_NEXT(a_start_enters_amp, push && kind == KIND_START,
		state_q.phase == PH_AMP_INIT && state_q.pass && !state_q.done)
	`LCVC_ASSERT_IMPL(a_coarse_in_range, 1'b1, state_q.cap_idx <= CAP_IDX_LIMIT)
	`LCVC_ASSERT_IMPL(a_done_is_idle, out_valid && done_res,
		request == REQ_NONE && threshold_select == TH_IDLE)

endmodule
